[rtl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter unit
// Holds the action and condition codes, the control word layout, the
// microcode program, the register map and the fixed-point constants.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned EstW   = 24;
  localparam int unsigned UncW   = 24;
  localparam int unsigned GainW  = 17;
  localparam int unsigned SampW  = 16;
  localparam int unsigned DenW   = 25;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned CntW   = 5;
  localparam int unsigned PcW    = 3;
  localparam int unsigned ProdW  = 43;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [GainW-1:0] GainOne     = 17'd65536;
  localparam logic [CntW-1:0]  DivLastCnt  = CntW'(QuoW - 1);
  localparam logic [UncW-1:0]  NoiseReset  = 24'd65536;
  localparam logic [EstW-1:0]  InitEstRst  = 24'd0;
  localparam logic [UncW-1:0]  InitUncRst  = 24'd65536;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] RegNoise   = 2'd0;
  localparam logic [1:0] RegInitEst = 2'd1;
  localparam logic [1:0] RegInitUnc = 2'd2;

  // Program step addresses.
  localparam logic [PcW-1:0] StepWait   = 3'd0;
  localparam logic [PcW-1:0] StepDiv    = 3'd1;
  localparam logic [PcW-1:0] StepGain   = 3'd2;
  localparam logic [PcW-1:0] StepMulEst = 3'd3;
  localparam logic [PcW-1:0] StepUpdEst = 3'd4;
  localparam logic [PcW-1:0] StepMulUnc = 3'd5;
  localparam logic [PcW-1:0] StepUpdUnc = 3'd6;
  localparam logic [PcW-1:0] StepEmit   = 3'd7;

  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_DIV,
    ACT_GAIN,
    ACT_MUL_EST,
    ACT_UPD_EST,
    ACT_MUL_UNC,
    ACT_UPD_UNC,
    ACT_EMIT
  } skf_act_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } skf_cond_e;

  typedef struct packed {
    skf_act_e        act;
    skf_cond_e       cond;
    logic [PcW-1:0]  target;
    logic            hold_exec;
  } skf_uword_t;

  typedef struct packed {
    skf_act_e act;
    logic     fire;
  } skf_ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_busy;
  } skf_status_t;

  typedef struct packed {
    logic             load_est;
    logic             load_unc;
    logic [EstW-1:0]  est;
    logic [UncW-1:0]  unc;
  } skf_cfg_t;

  // Microcode program. A true condition jumps to target; otherwise the
  // step counter advances (the last step wraps back to the wait step).
  function automatic skf_uword_t skf_ucode(input logic [PcW-1:0] pc);
    skf_uword_t w;
    w = '{act: ACT_LOAD, cond: COND_NO_INPUT, target: StepWait, hold_exec: 1'b0};
    case (pc)
      StepWait:   w = '{act: ACT_LOAD,    cond: COND_NO_INPUT, target: StepWait,
                        hold_exec: 1'b0};
      StepDiv:    w = '{act: ACT_DIV,     cond: COND_CNT_NZ,   target: StepDiv,
                        hold_exec: 1'b1};
      StepGain:   w = '{act: ACT_GAIN,    cond: COND_NEVER,    target: StepWait,
                        hold_exec: 1'b0};
      StepMulEst: w = '{act: ACT_MUL_EST, cond: COND_NEVER,    target: StepWait,
                        hold_exec: 1'b0};
      StepUpdEst: w = '{act: ACT_UPD_EST, cond: COND_NEVER,    target: StepWait,
                        hold_exec: 1'b0};
      StepMulUnc: w = '{act: ACT_MUL_UNC, cond: COND_NEVER,    target: StepWait,
                        hold_exec: 1'b0};
      StepUpdUnc: w = '{act: ACT_UPD_UNC, cond: COND_NEVER,    target: StepWait,
                        hold_exec: 1'b0};
      StepEmit:   w = '{act: ACT_EMIT,    cond: COND_OUT_BUSY, target: StepEmit,
                        hold_exec: 1'b0};
      default:    w = '{act: ACT_LOAD,    cond: COND_NO_INPUT, target: StepWait,
                        hold_exec: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[rtl/skf_if.sv]
// ----------------------------------------------------------------------------
// skf_if: stream channels of the scalar Kalman filter unit
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface skf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] filtered;
  logic        [16:0] kalman_gain;

  modport source (output valid, output filtered, output kalman_gain, input ready);
  modport sink   (input valid, input filtered, input kalman_gain, output ready);
endinterface

[rtl/skf_regs.sv]
// ----------------------------------------------------------------------------
// skf_regs: configuration register file
// APB-style slave holding the noise and the two initial-state registers.
// ----------------------------------------------------------------------------
module skf_regs
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [UncW-1:0]  noise_o,
  output skf_cfg_t         cfg_o
);

  logic [UncW-1:0] noise_q, noise_d;
  logic [EstW-1:0] init_est_q, init_est_d;
  logic [UncW-1:0] init_unc_q, init_unc_d;
  logic            wr;
  logic [1:0]      idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    noise_d    = noise_q;
    init_est_d = init_est_q;
    init_unc_d = init_unc_q;
    if (wr) begin
      case (idx)
        RegNoise:   noise_d    = pwdata[UncW-1:0];
        RegInitEst: init_est_d = pwdata[EstW-1:0];
        RegInitUnc: init_unc_d = pwdata[UncW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q    <= NoiseReset;
      init_est_q <= InitEstRst;
      init_unc_q <= InitUncRst;
    end else begin
      noise_q    <= noise_d;
      init_est_q <= init_est_d;
      init_unc_q <= init_unc_d;
    end
  end

  always_comb begin
    case (idx)
      RegNoise:   prdata = {8'd0, noise_q};
      RegInitEst: prdata = {8'd0, init_est_q};
      RegInitUnc: prdata = {8'd0, init_unc_q};
      default:    prdata = '0;
    endcase
  end

  // A write to an initial register also reloads the matching state.
  assign noise_o = noise_q;
  assign cfg_o   = '{load_est: wr && (idx == RegInitEst),
                     load_unc: wr && (idx == RegInitUnc),
                     est:      pwdata[EstW-1:0],
                     unc:      pwdata[UncW-1:0]};

endmodule

[rtl/skf_sequencer.sv]
// ----------------------------------------------------------------------------
// skf_sequencer: microcode step counter
// Fetches the control word of the current step and resolves its jump.
// ----------------------------------------------------------------------------
module skf_sequencer
  import skf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  skf_status_t status_i,
  output skf_ctrl_t   ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  skf_uword_t     word;
  logic           jump;

  assign word = skf_ucode(pc_q);

  always_comb begin
    case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_INPUT: jump = !in_valid_i;
      COND_CNT_NZ:   jump = !status_i.cnt_zero;
      COND_OUT_BUSY: jump = status_i.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // The step counter wraps from the last step back to the wait step.
  assign pc_d = jump ? word.target : pc_q + PcW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = '{act: word.act, fire: !jump || word.hold_exec};

endmodule

[rtl/skf_datapath.sv]
// ----------------------------------------------------------------------------
// skf_datapath: filter state, divider and shared multiplier
// Executes one action per cycle as the control word selects, when the word fires.
// ----------------------------------------------------------------------------
module skf_datapath
  import skf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skf_ctrl_t         ctrl_i,
  input  skf_cfg_t          cfg_i,
  input  logic [UncW-1:0]   noise_i,
  input  logic [SampW-1:0]  sample_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [EstW-1:0]   filtered_o,
  output logic [GainW-1:0]  gain_o,
  output skf_status_t       status_o
);

  logic [EstW-1:0]   est_q, est_d;
  logic [UncW-1:0]   unc_q, unc_d;
  logic [SampW-1:0]  sample_q;
  logic [DenW-1:0]   den_q;
  logic [DenW-1:0]   rem_q;
  logic [QuoW-1:0]   shl_q;
  logic [QuoW-1:0]   quo_q;
  logic [CntW-1:0]   cnt_q;
  logic [GainW-1:0]  gain_q;
  logic [ProdW-1:0]  prod_q;
  logic              out_valid_q;
  logic [EstW-1:0]   filt_q;
  logic [GainW-1:0]  ogain_q;

  logic [DenW:0]          trial;
  logic                   q_bit;
  logic signed [DenW-1:0] diff;
  logic signed [17:0]     mul_a;
  logic signed [24:0]     mul_b;
  logic signed [42:0]     mul_p;

  function automatic logic is_act(input skf_ctrl_t c, input skf_act_e a);
    return c.fire && (c.act == a);
  endfunction

  // One restoring division step: shift in the next dividend bit.
  assign trial = {rem_q, shl_q[QuoW-1]};
  assign q_bit = (trial >= {1'b0, den_q});

  assign diff = $signed({sample_q[SampW-1], sample_q, 8'd0})
              - $signed({est_q[EstW-1], est_q});

  always_comb begin
    if (ctrl_i.act == ACT_MUL_UNC) begin
      mul_a = $signed({1'b0, GainOne - gain_q});
      mul_b = $signed({1'b0, unc_q});
    end else begin
      mul_a = $signed({1'b0, gain_q});
      mul_b = diff;
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    est_d = est_q;
    unc_d = unc_q;
    if (is_act(ctrl_i, ACT_UPD_EST)) est_d = est_q + prod_q[39:16];
    if (is_act(ctrl_i, ACT_UPD_UNC)) unc_d = prod_q[39:16];
    if (cfg_i.load_est) est_d = cfg_i.est;
    if (cfg_i.load_unc) unc_d = cfg_i.unc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= InitEstRst;
      unc_q       <= InitUncRst;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      est_q <= est_d;
      unc_q <= unc_d;
      if (is_act(ctrl_i, ACT_LOAD)) begin
        cnt_q <= DivLastCnt;
      end else if (is_act(ctrl_i, ACT_DIV)) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (is_act(ctrl_i, ACT_EMIT)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_act(ctrl_i, ACT_LOAD)) begin
      sample_q <= sample_i;
      den_q    <= {1'b0, unc_q} + {1'b0, noise_i};
      rem_q    <= {2'b00, unc_q[UncW-1:1]};
      shl_q    <= {unc_q[0], 16'd0};
      quo_q    <= '0;
    end
    if (is_act(ctrl_i, ACT_DIV)) begin
      rem_q <= q_bit ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      shl_q <= {shl_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], q_bit};
    end
    // A zero denominator only arises with zero uncertainty: gain is zero.
    if (is_act(ctrl_i, ACT_GAIN)) begin
      gain_q <= (den_q == '0) ? '0 : quo_q;
    end
    if (is_act(ctrl_i, ACT_MUL_EST) || is_act(ctrl_i, ACT_MUL_UNC)) begin
      prod_q <= mul_p;
    end
    if (is_act(ctrl_i, ACT_EMIT)) begin
      filt_q  <= est_q;
      ogain_q <= gain_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;
  assign gain_o      = ogain_q;
  assign status_o    = '{cnt_zero: (cnt_q == '0),
                         out_busy: out_valid_q && !out_ready_i};

endmodule

[rtl/scalar_kalman_filter_unit.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit: one-state Kalman filter without process noise
// Top level: configuration registers, microcode sequencer and datapath.
// ----------------------------------------------------------------------------
// Each sample transaction runs one filter step and yields one result
// transaction carrying the new Q16.8 estimate and the Q1.16 gain. From
// acceptance to the result being offered, a step runs a load step, 17
// iterations of the restoring divider that forms the gain, and
// six further program steps that share one 18x25 multiplier for the
// estimate and uncertainty updates and then present the result. The next
// sample is taken in the cycle after the result is handed to the output
// register, so no new sample is taken while a step is still running; a
// stalled result holds the program at its last step. Configuration is
// to be written through the APB port only while the block is idle; the
// block itself does not enforce this. Writing an initial register reloads
// the matching state at once. No clearing pass is needed after reset.
module scalar_kalman_filter_unit
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  skf_in_if.sink           in_chan_i,
  skf_out_if.source        out_chan_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  skf_ctrl_t       ctrl;
  skf_status_t     status;
  skf_cfg_t        cfg;
  logic [UncW-1:0] noise;
  logic [EstW-1:0] filtered;

  skf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .noise_o (noise),
    .cfg_o   (cfg)
  );

  skf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  skf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .noise_i     (noise),
    .sample_i    (in_chan_i.sample),
    .out_ready_i (out_chan_o.ready),
    .out_valid_o (out_chan_o.valid),
    .filtered_o  (filtered),
    .gain_o      (out_chan_o.kalman_gain),
    .status_o    (status)
  );

  // The wait step is the only one that takes a sample.
  assign in_chan_i.ready     = (ctrl.act == ACT_LOAD);
  assign out_chan_o.filtered = $signed(filtered);

  // A sample transaction starts a program run, so the next cycle is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_chan_i.ready) |=> !in_chan_i.ready)
    else $error("sample accepted twice in a row");

  // The gain never exceeds one.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid |-> (out_chan_o.kalman_gain <= GainOne))
    else $error("gain above one");

  // A new result only appears at the end of a program run.
  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_chan_o.valid) |-> $past(!in_chan_i.ready))
    else $error("result raised outside the emit step");

endmodule
